FILE: rtl/core/accumulator_bytecode_execute_defines.svh
// Assertion macros for the accumulator bytecode execute unit.
`ifndef ACCUMULATOR_BYTECODE_EXECUTE_DEFINES_SVH
`define ACCUMULATOR_BYTECODE_EXECUTE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ABE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abe check failed");

// next-cycle implication, disabled in reset
`define ABE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abe check failed");

`endif

FILE: rtl/core/abe_pkg.sv
// Shared types, opcodes and constants for the accumulator bytecode execute unit.
package abe_pkg;

  localparam int INSTR_SIZE = 2;
  localparam int MEM_CELLS  = 256;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int OFFS_W     = 9;
  localparam int OFFS_PROD_W = 8 + $clog2(INSTR_SIZE + 1) + 1;

  localparam logic [3:0] OP_OUT_IMM  = 4'd0;
  localparam logic [3:0] OP_OUT_CELL = 4'd1;
  localparam logic [3:0] OP_IN_CELL  = 4'd2;
  localparam logic [3:0] OP_LD_IMM   = 4'd3;
  localparam logic [3:0] OP_LD_CELL  = 4'd4;
  localparam logic [3:0] OP_ST_CELL  = 4'd5;
  localparam logic [3:0] OP_ADD_IMM  = 4'd6;
  localparam logic [3:0] OP_ADD_CELL = 4'd7;
  localparam logic [3:0] OP_SUB_IMM  = 4'd8;
  localparam logic [3:0] OP_SUB_CELL = 4'd9;
  localparam logic [3:0] OP_MUL      = 4'd10;
  localparam logic [3:0] OP_DIV      = 4'd11;
  localparam logic [3:0] OP_SKIP     = 4'd12;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIV0    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  localparam logic [7:0] ACC_ADDR = 8'h00;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] arg;
    logic [7:0] in_byte;
  } abe_in_t;

  typedef struct packed {
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              skip_taken;
    logic [OFFS_W-1:0] pc_offset;
    logic [1:0]        status;
  } abe_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_DONE
  } abe_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic div_step;
    logic emit;
  } abe_cmd_t;

  typedef struct packed {
    logic div_go;
    logic div_last;
    logic out_busy;
  } abe_stat_t;

endpackage

FILE: rtl/core/abe_ctrl.sv
// Sequencing state machine for the accumulator bytecode execute unit.
module abe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  abe_pkg::abe_stat_t stat,
  output abe_pkg::abe_cmd_t  cmd
);
  import abe_pkg::*;

  abe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = stat.div_go ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (stat.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_READ: cmd.rd = 1'b1;
      S_EXEC: cmd.exec = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_DONE: cmd.emit = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/abe_dpath.sv
// Datapath: data memory, accumulator, ALU, bit-serial divider and result register.
module abe_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  abe_pkg::abe_in_t   in_data,
  input  abe_pkg::abe_cmd_t  cmd,
  output abe_pkg::abe_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output abe_pkg::abe_out_t  out_data
);
  import abe_pkg::*;

  logic [3:0] func_r;
  logic [7:0] arg_r;
  logic [7:0] inb_r;

  logic [7:0]           mem [MEM_CELLS];
  logic [MEM_CELLS-1:0] vld_r;
  logic [7:0]           mem_rd_r;
  logic                 vld_rd_r;
  logic [7:0]           acc_r;

  logic [7:0]           quo_r, rem_r, dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  abe_out_t res_r, res_nxt;
  abe_out_t out_r;
  logic     out_vld_r;

  logic [7:0]             cell_rd;
  logic [15:0]            prod;
  logic [OFFS_PROD_W-1:0] offs_prod;
  logic                   acc_we, mem_we;
  logic [7:0]             acc_wd, mem_wd;
  logic [8:0]             trial;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      arg_r  <= in_data.arg;
      inb_r  <= in_data.in_byte;
    end
  end

  // cell 0 lives in acc_r; other cells read as zero until first written
  assign cell_rd = (arg_r == ACC_ADDR) ? acc_r : (vld_rd_r ? mem_rd_r : 8'h00);
  assign prod = {8'h00, acc_r} * {8'h00, cell_rd};
  assign offs_prod = OFFS_PROD_W'(arg_r) * OFFS_PROD_W'(INSTR_SIZE);

  always_comb begin
    res_nxt = '0;
    acc_we  = 1'b0;
    acc_wd  = acc_r;
    mem_we  = 1'b0;
    mem_wd  = inb_r;
    case (func_r)
      OP_OUT_IMM: begin
        res_nxt.out_valid = 1'b1;
        res_nxt.out_byte  = arg_r;
      end
      OP_OUT_CELL: begin
        res_nxt.out_valid = 1'b1;
        res_nxt.out_byte  = cell_rd;
      end
      OP_IN_CELL: begin
        mem_we = 1'b1;
        mem_wd = inb_r;
      end
      OP_LD_IMM: begin
        acc_we = 1'b1;
        acc_wd = arg_r;
      end
      OP_LD_CELL: begin
        acc_we = 1'b1;
        acc_wd = cell_rd;
      end
      OP_ST_CELL: begin
        mem_we = 1'b1;
        mem_wd = acc_r;
      end
      OP_ADD_IMM: begin
        acc_we = 1'b1;
        acc_wd = acc_r + arg_r;
      end
      OP_ADD_CELL: begin
        acc_we = 1'b1;
        acc_wd = acc_r + cell_rd;
      end
      OP_SUB_IMM: begin
        acc_we = 1'b1;
        acc_wd = acc_r - arg_r;
      end
      OP_SUB_CELL: begin
        acc_we = 1'b1;
        acc_wd = acc_r - cell_rd;
      end
      OP_MUL: begin
        acc_we = 1'b1;
        acc_wd = prod[7:0];
      end
      OP_DIV: begin
        if (cell_rd == 8'h00) res_nxt.status = ST_DIV0;
      end
      OP_SKIP: begin
        if (acc_r != 8'h00) begin
          res_nxt.skip_taken = 1'b1;
          res_nxt.pc_offset  = offs_prod[OFFS_W-1:0];
        end
      end
      default: res_nxt.status = ST_ILLEGAL;
    endcase
    // writes aimed at cell 0 land in the accumulator
    if (mem_we && arg_r == ACC_ADDR) begin
      acc_we = 1'b1;
      acc_wd = mem_wd;
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) mem_rd_r <= mem[arg_r];
    if (cmd.exec && mem_we) mem[arg_r] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.exec && mem_we) begin
      vld_r[arg_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) vld_rd_r <= vld_r[arg_r];
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_r, quo_r[7]} - {1'b0, dvs_r};

  assign stat.div_go   = (func_r == OP_DIV) && (cell_rd != 8'h00);
  assign stat.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.out_busy = out_vld_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      quo_r <= acc_r;
      rem_r <= 8'h00;
      dvs_r <= cell_rd;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (!trial[8]) begin
        rem_r <= trial[7:0];
        quo_r <= {quo_r[6:0], 1'b1};
      end else begin
        rem_r <= {rem_r[6:0], quo_r[7]};
        quo_r <= {quo_r[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 8'h00;
    end else if (cmd.exec && acc_we) begin
      acc_r <= acc_wd;
    end else if (cmd.div_step && stat.div_last) begin
      acc_r <= {quo_r[6:0], !trial[8]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) res_r <= res_nxt;
    if (cmd.emit) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/accumulator_bytecode_execute.sv
// An instruction is accepted in S_IDLE, then passes S_READ, S_EXEC, S_DIV (only for a divide by
// a nonzero cell) and S_DONE, which waits while the output register is busy, then registers the
// result beat. The registered single-port data memory read and the one-bit-per-cycle divider
// set the pace. A new instruction is taken while a beat still waits in the output register.
// Reset clears the accumulator and the per-cell valid bits; cells read zero after.
module accumulator_bytecode_execute (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  abe_pkg::abe_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output abe_pkg::abe_out_t out_data
);
  import abe_pkg::*;

  abe_cmd_t  cmd;
  abe_stat_t stat;

  abe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  abe_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/abe_checker.sv
// Port-level checks for the accumulator bytecode execute unit, bound to the top level.
`include "accumulator_bytecode_execute_defines.svh"

module abe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input abe_pkg::abe_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input abe_pkg::abe_out_t out_data
);
  import abe_pkg::*;

  `ABE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ABE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `ABE_ASSERT_NOW(a_status_legal, out_valid, out_data.status != 2'd3)
  `ABE_ASSERT_NOW(a_byte_quiet, out_valid && !out_data.out_valid, out_data.out_byte == 8'h00)
  `ABE_ASSERT_NOW(a_offs_quiet, out_valid && !out_data.skip_taken,
                  out_data.pc_offset == '0)

endmodule

bind accumulator_bytecode_execute abe_checker u_abe_checker (.*);

FILE: verif/accumulator_bytecode_execute_checker.sv
// Scoreboard for the accumulator bytecode execute unit: predicts and checks every result beat.
module accumulator_bytecode_execute_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  abe_pkg::abe_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  abe_pkg::abe_out_t out_data,
  output int                mismatches,
  output int                pending,
  output int                beats_checked,
  output int                div0_seen,
  output int                skips_seen
);
  import abe_pkg::*;

  localparam int PRINT_CAP = 50;

  logic [7:0] data_mem [MEM_CELLS];
  abe_out_t   predicted_results [$];

  initial begin
    mismatches    = 0;
    pending       = 0;
    beats_checked = 0;
    div0_seen     = 0;
    skips_seen    = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("beat %0d: %s got 0x%0h want 0x%0h", beats_checked, what, got, want);
    end
    mismatches++;
  endtask

  // cell 0 doubles as the accumulator
  function automatic abe_out_t run_instr(input abe_in_t ins);
    abe_out_t   r;
    logic [7:0] acc;
    logic [7:0] cell_val;
    logic [31:0] prod;
    r        = '0;
    acc      = data_mem[ACC_ADDR];
    cell_val = data_mem[ins.arg];
    r.status = ST_OK;
    case (ins.func)
      OP_OUT_IMM: begin
        r.out_valid = 1'b1;
        r.out_byte  = ins.arg;
      end
      OP_OUT_CELL: begin
        r.out_valid = 1'b1;
        r.out_byte  = cell_val;
      end
      OP_IN_CELL:  data_mem[ins.arg]  = ins.in_byte;
      OP_LD_IMM:   data_mem[ACC_ADDR] = ins.arg;
      OP_LD_CELL:  data_mem[ACC_ADDR] = cell_val;
      OP_ST_CELL:  data_mem[ins.arg]  = acc;
      OP_ADD_IMM:  data_mem[ACC_ADDR] = acc + ins.arg;
      OP_ADD_CELL: data_mem[ACC_ADDR] = acc + cell_val;
      OP_SUB_IMM:  data_mem[ACC_ADDR] = acc - ins.arg;
      OP_SUB_CELL: data_mem[ACC_ADDR] = acc - cell_val;
      OP_MUL:      data_mem[ACC_ADDR] = 8'((16'(acc) * 16'(cell_val)));
      OP_DIV: begin
        if (cell_val == 8'h00) begin
          r.status = ST_DIV0;
        end else begin
          data_mem[ACC_ADDR] = acc / cell_val;
        end
      end
      OP_SKIP: begin
        if (acc != 8'h00) begin
          prod         = 32'(ins.arg) * 32'(INSTR_SIZE);
          r.skip_taken = 1'b1;
          r.pc_offset  = prod[OFFS_W-1:0];
        end
      end
      default: r.status = ST_ILLEGAL;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    abe_out_t want;
    if (!rst_n) begin
      for (int c = 0; c < MEM_CELLS; c++) begin
        data_mem[c] = 8'h00;
      end
      predicted_results.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report("beat with no instruction outstanding", 32'(out_data), 32'h0);
        end else begin
          want = predicted_results.pop_front();
          if (out_data.out_valid != want.out_valid) begin
            report("out_valid", 32'(out_data.out_valid), 32'(want.out_valid));
          end
          if (out_data.out_byte != want.out_byte) begin
            report("out_byte", 32'(out_data.out_byte), 32'(want.out_byte));
          end
          if (out_data.skip_taken != want.skip_taken) begin
            report("skip_taken", 32'(out_data.skip_taken), 32'(want.skip_taken));
          end
          if (out_data.pc_offset != want.pc_offset) begin
            report("pc_offset", 32'(out_data.pc_offset), 32'(want.pc_offset));
          end
          if (out_data.status != want.status) begin
            report("status", 32'(out_data.status), 32'(want.status));
          end
          if (want.status == ST_DIV0) div0_seen++;
          if (want.skip_taken) skips_seen++;
          beats_checked++;
        end
      end
      if (in_valid && in_ready) begin
        predicted_results.push_back(run_instr(in_data));
      end
      pending <= predicted_results.size();
    end
  end

endmodule

FILE: verif/accumulator_bytecode_execute_test.sv
// Testbench top for the accumulator bytecode execute unit: clock, reset, stimulus and verdict.
module accumulator_bytecode_execute_test;
  import abe_pkg::*;

  localparam int RANDOM_INSTRS = 1750;
  localparam int CALM_TAIL     = 200;
  localparam int DRAIN_EVERY   = 400;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  abe_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  abe_out_t out_data;

  int mismatches;
  int pending;
  int beats_checked;
  int div0_seen;
  int skips_seen;

  bit calm;
  int idle_level;
  int sent;

  accumulator_bytecode_execute i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  accumulator_bytecode_execute_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .beats_checked(beats_checked),
    .div0_seen    (div0_seen),
    .skips_seen   (skips_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver stalls
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic abe_in_t make_instr(input logic [3:0] f, input logic [7:0] a,
                                         input logic [7:0] b);
    abe_in_t i;
    i.func    = f;
    i.arg     = a;
    i.in_byte = b;
    return i;
  endfunction

  function automatic abe_in_t rand_instr();
    abe_in_t i;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      i.func = 4'($urandom_range(32'(OP_SKIP) + 1, 32'hF));
    end else begin
      i.func = 4'($urandom_range(32'(OP_OUT_IMM), 32'(OP_SKIP)));
    end
    case (i.func)
      OP_OUT_IMM, OP_LD_IMM, OP_ADD_IMM, OP_SUB_IMM, OP_SKIP: begin
        pick = $urandom_range(0, 9);
        if (pick == 0) i.arg = 8'h00;
        else if (pick == 1) i.arg = 8'hFF;
        else i.arg = 8'($urandom_range(0, 255));
      end
      default: begin
        // a small set of cells so that stores are read back often
        pick = $urandom_range(0, 9);
        if (pick < 7) i.arg = 8'($urandom_range(0, 3));
        else if (pick < 8) i.arg = 8'(252 + $urandom_range(0, 3));
        else i.arg = 8'($urandom_range(0, 255));
      end
    endcase
    i.in_byte = 8'($urandom_range(0, 255));
    return i;
  endfunction

  task automatic send_instr(input abe_in_t instr);
    in_valid <= 1'b1;
    in_data  <= instr;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!calm && idle_level != 0 &&
        $urandom_range(0, (idle_level == 1) ? 11 : 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int n;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    calm       = 1'b0;
    idle_level = 1;
    sent       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_instr(make_instr(OP_OUT_IMM,  8'h00, 8'hFF));
    send_instr(make_instr(OP_OUT_IMM,  8'hFF, 8'h00));
    send_instr(make_instr(OP_OUT_CELL, 8'h00, 8'h5A));
    send_instr(make_instr(OP_DIV,      8'h05, 8'hA5));
    send_instr(make_instr(OP_SKIP,     8'h7F, 8'h00));
    send_instr(make_instr(OP_LD_IMM,   8'hFF, 8'h00));
    send_instr(make_instr(OP_SKIP,     8'hFF, 8'h00));
    send_instr(make_instr(OP_ST_CELL,  8'hFF, 8'h00));
    send_instr(make_instr(OP_IN_CELL,  8'h80, 8'hFF));
    send_instr(make_instr(OP_IN_CELL,  8'h02, 8'h03));
    send_instr(make_instr(OP_OUT_CELL, 8'h80, 8'h00));
    send_instr(make_instr(OP_ADD_IMM,  8'h01, 8'h00));
    send_instr(make_instr(OP_SUB_IMM,  8'h01, 8'h00));
    send_instr(make_instr(OP_ADD_CELL, 8'h80, 8'h00));
    send_instr(make_instr(OP_SUB_CELL, 8'hFF, 8'h00));
    send_instr(make_instr(OP_MUL,      8'h80, 8'h00));
    send_instr(make_instr(OP_LD_CELL,  8'h80, 8'h00));
    send_instr(make_instr(OP_DIV,      8'h02, 8'h00));
    send_instr(make_instr(OP_DIV,      8'h00, 8'h00));
    send_instr(make_instr(OP_ST_CELL,  8'h10, 8'h00));
    for (n = 32'(OP_SKIP) + 1; n <= 32'hF; n++) begin
      send_instr(make_instr(4'(n), 8'hFF, 8'hFF));
    end
    send_instr(make_instr(OP_SKIP,     8'h01, 8'h00));
    send_instr(make_instr(OP_IN_CELL,  8'h00, 8'h00));
    send_instr(make_instr(OP_OUT_CELL, 8'h00, 8'h00));
    drain_results();

    for (n = 0; n < RANDOM_INSTRS; n++) begin
      if (n % 128 == 0) idle_level = $urandom_range(0, 2);
      if (n >= RANDOM_INSTRS - CALM_TAIL) calm = 1'b1;
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain_results();
      send_instr(rand_instr());
    end
    drain_results();
    repeat (20) @(posedge clk);

    $display("%0d instructions sent, %0d result beats checked against the prediction",
             sent, beats_checked);
    $display("%0d divides by zero and %0d taken skips among them", div0_seen, skips_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
